[src/cddn_pkg.sv]
// Shared types, constants and helper functions for the civil date / day number converter.
package cddn_pkg;

    // Field widths
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DOM_W   = 5;
    localparam int unsigned DAYS_W  = 22;
    localparam int unsigned WDAY_W  = 3;

    // Pipeline depth, identical for both conversion paths
    localparam int unsigned CDDN_STAGES = 10;

    // Calendar constants
    localparam logic [19:0] EPOCH_OFFSET = 20'd719468;  // 0000-03-01 era base to 1970-01-01
    localparam logic [17:0] ERA_DAYS     = 18'd146097;  // days in a 400-year era
    localparam logic [17:0] ERA_LAST     = 18'd146096;  // last day of an era
    localparam logic [8:0]  YEAR_DAYS    = 9'd365;
    localparam logic [8:0]  ERA_YEARS    = 9'd400;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [2:0]  WDAY_EPOCH   = 3'd4;        // 1970-01-01 was a Thursday

    // Reciprocal multipliers: q = (x * MUL) >> SHIFT, exact for the operand ranges used
    localparam logic [14:0] DIV400_MUL   = 15'(((64'd1 << 23) + 64'd399) / 64'd400);
    localparam logic [9:0]  DIV100_MUL   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [23:0] ERA_MUL      = 24'(((64'd1 << 41) + 64'd146096) / 64'd146097);
    localparam logic [18:0] DIV1460_MUL  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] DIV36524_MUL = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam logic [18:0] DIV365_MUL   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [11:0] DIV153_MUL   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

    typedef enum logic {
        CMD_TO_DAYS = 1'b0,
        CMD_TO_DATE = 1'b1
    } cddn_cmd_t;

    typedef struct packed {
        cddn_cmd_t           command;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DOM_W-1:0]    day_of_month;
        logic [DAYS_W-1:0]   day_number;
    } cddn_in_t;

    typedef struct packed {
        logic [DAYS_W-1:0]   out_day_number;
        logic [YEAR_W-1:0]   out_year;
        logic [MONTH_W-1:0]  out_month;
        logic [DOM_W-1:0]    out_day_of_month;
        logic [WDAY_W-1:0]   weekday;
    } cddn_out_t;

    // Stage load enables handed from the pipeline control to the datapaths
    typedef struct packed {
        logic [CDDN_STAGES-1:0] load;
    } cddn_ctrl_t;

    // First day-of-year of a March-based month index: (153 * m + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            4'd12:   r = 9'd367;
            4'd13:   r = 9'd398;
            4'd14:   r = 9'd428;
            default: r = 9'd459;
        endcase
        return r;
    endfunction

    // x mod 7 by folding octal digits (8 is 1 mod 7)
    function automatic logic [2:0] mod7(input logic [22:0] x);
        logic [5:0] s;
        logic [3:0] t;
        logic [3:0] u;
        s = 6'(x[22:21]);
        for (int k = 0; k < 7; k++)
        begin
            s = s + 6'(x[3*k +: 3]);
        end
        t = 4'(s[5:3]) + 4'(s[2:0]);
        u = 4'(t[3]) + 4'(t[2:0]);
        return (u == 4'd7) ? 3'd0 : u[2:0];
    endfunction

endpackage

[src/cddn_if.sv]
// Valid/ready channel interfaces for the request and result words.
interface cddn_in_if
    import cddn_pkg::*;
();
    logic     valid;
    logic     ready;
    cddn_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cddn_out_if
    import cddn_pkg::*;
();
    logic      valid;
    logic      ready;
    cddn_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/cddn_date_pipe.sv]
// Date to day number datapath: six compute stages, then delay stages to match depth.
module cddn_date_pipe
    import cddn_pkg::*;
(
    input  logic               clk,
    input  cddn_ctrl_t         ctrl,
    input  logic [YEAR_W-1:0]  year,
    input  logic [MONTH_W-1:0] month,
    input  logic [DOM_W-1:0]   day_of_month,
    output logic [DAYS_W-1:0]  day_number,
    output logic [WDAY_W-1:0]  weekday,
    output logic [YEAR_W-1:0]  year_echo,
    output logic [MONTH_W-1:0] month_echo,
    output logic [DOM_W-1:0]   dom_echo
);

    localparam int unsigned DAYS_FIRST = 4;
    localparam int unsigned WDAY_FIRST = 5;

    // Stage 1: shifted year, March-based day of year
    logic              s1_mlow;
    logic [3:0]        s1_mshift;
    logic [13:0]       s1_ypos_next, s1_ypos_reg;
    logic              s1_neg_next, s1_neg_reg;
    logic [9:0]        s1_doy_next, s1_doy_reg;

    // Stage 2: era = y / 400
    logic [28:0]       s2_prod;
    logic [5:0]        s2_era_next, s2_era_reg;
    logic [13:0]       s2_ypos_reg;
    logic              s2_neg_reg;
    logic [9:0]        s2_doy_reg;

    // Stage 3: year of era, era day base
    logic [13:0]       s3_yoe_full;
    logic [8:0]        s3_yoe_next, s3_yoe_reg;
    logic [DAYS_W-1:0] s3_base_next, s3_base_reg;
    logic [9:0]        s3_doy_reg;

    // Stage 4: year part of day of era
    logic [18:0]       s4_p100;
    logic [2:0]        s4_q100_next, s4_q100_reg;
    logic [17:0]       s4_h_next, s4_h_reg;
    logic [DAYS_W-1:0] s4_base_reg;
    logic [9:0]        s4_doy_reg;

    // Stage 5 and on: day number, weekday
    logic [DAYS_W-1:0] s5_days_next;
    logic [WDAY_W-1:0] s6_wd_next;
    logic [DAYS_W-1:0] days_reg [DAYS_FIRST:CDDN_STAGES-1];
    logic [WDAY_W-1:0] wd_reg [WDAY_FIRST:CDDN_STAGES-1];

    // Echo of the date fields
    logic [YEAR_W-1:0]  yr_echo_reg [CDDN_STAGES];
    logic [MONTH_W-1:0] mo_echo_reg [CDDN_STAGES];
    logic [DOM_W-1:0]   dm_echo_reg [CDDN_STAGES];

    always_comb
    begin
        s1_mlow      = (month <= MONTH_FEB);
        s1_neg_next  = s1_mlow && (year == '0);
        s1_ypos_next = year - YEAR_W'(s1_mlow);
        s1_mshift    = s1_mlow ? (month + 4'd9) : (month - 4'd3);
        s1_doy_next  = 10'(month_start(s1_mshift)) + 10'(day_of_month) - 10'd1;
    end

    assign s2_prod     = 29'(s1_ypos_reg) * 29'(DIV400_MUL);
    assign s2_era_next = s2_prod[28:23];

    // Year zero before March sits in era -1, year of era 399
    always_comb
    begin
        s3_yoe_full = s2_ypos_reg - 14'(s2_era_reg) * 14'(ERA_YEARS);
        if (s2_neg_reg)
        begin
            s3_yoe_next  = 9'd399;
            s3_base_next = DAYS_W'(0) - DAYS_W'(ERA_DAYS);
        end
        else
        begin
            s3_yoe_next  = s3_yoe_full[8:0];
            s3_base_next = DAYS_W'(s2_era_reg) * DAYS_W'(ERA_DAYS);
        end
    end

    assign s4_p100      = 19'(s3_yoe_reg) * 19'(DIV100_MUL);
    assign s4_q100_next = s4_p100[18:16];
    assign s4_h_next    = 18'(s3_yoe_reg) * 18'(YEAR_DAYS) + 18'(s3_yoe_reg[8:2]);

    assign s5_days_next = s4_base_reg + DAYS_W'(s4_h_reg) - DAYS_W'(s4_q100_reg)
                        + {{(DAYS_W-10){s4_doy_reg[9]}}, s4_doy_reg}
                        - DAYS_W'(EPOCH_OFFSET);

    assign s6_wd_next = mod7(23'(days_reg[DAYS_FIRST]) + 23'(WDAY_EPOCH));

    // Compute stage registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            s1_ypos_reg <= s1_ypos_next;
            s1_neg_reg  <= s1_neg_next;
            s1_doy_reg  <= s1_doy_next;
        end
        if (ctrl.load[1])
        begin
            s2_era_reg  <= s2_era_next;
            s2_ypos_reg <= s1_ypos_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_doy_reg  <= s1_doy_reg;
        end
        if (ctrl.load[2])
        begin
            s3_yoe_reg  <= s3_yoe_next;
            s3_base_reg <= s3_base_next;
            s3_doy_reg  <= s2_doy_reg;
        end
        if (ctrl.load[3])
        begin
            s4_q100_reg <= s4_q100_next;
            s4_h_reg    <= s4_h_next;
            s4_base_reg <= s3_base_reg;
            s4_doy_reg  <= s3_doy_reg;
        end
        if (ctrl.load[DAYS_FIRST])
        begin
            days_reg[DAYS_FIRST] <= s5_days_next;
        end
        if (ctrl.load[WDAY_FIRST])
        begin
            wd_reg[WDAY_FIRST] <= s6_wd_next;
        end
    end

    // Delay stages for the result
    for (genvar k = DAYS_FIRST + 1; k < CDDN_STAGES; k++)
    begin : g_days_dly
        always_ff @(posedge clk)
        begin
            if (ctrl.load[k])
            begin
                days_reg[k] <= days_reg[k-1];
            end
        end
    end

    for (genvar k = WDAY_FIRST + 1; k < CDDN_STAGES; k++)
    begin : g_wd_dly
        always_ff @(posedge clk)
        begin
            if (ctrl.load[k])
            begin
                wd_reg[k] <= wd_reg[k-1];
            end
        end
    end

    // Echo line for the input date
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            yr_echo_reg[0] <= year;
            mo_echo_reg[0] <= month;
            dm_echo_reg[0] <= day_of_month;
        end
    end

    for (genvar k = 1; k < CDDN_STAGES; k++)
    begin : g_echo
        always_ff @(posedge clk)
        begin
            if (ctrl.load[k])
            begin
                yr_echo_reg[k] <= yr_echo_reg[k-1];
                mo_echo_reg[k] <= mo_echo_reg[k-1];
                dm_echo_reg[k] <= dm_echo_reg[k-1];
            end
        end
    end

    assign day_number = days_reg[CDDN_STAGES-1];
    assign weekday    = wd_reg[CDDN_STAGES-1];
    assign year_echo  = yr_echo_reg[CDDN_STAGES-1];
    assign month_echo = mo_echo_reg[CDDN_STAGES-1];
    assign dom_echo   = dm_echo_reg[CDDN_STAGES-1];

endmodule

[src/cddn_day_pipe.sv]
// Day number to date datapath: ten stages, one constant multiply or add chain per stage.
module cddn_day_pipe
    import cddn_pkg::*;
(
    input  logic               clk,
    input  cddn_ctrl_t         ctrl,
    input  logic [DAYS_W-1:0]  day_number,
    output logic [YEAR_W-1:0]  year,
    output logic [MONTH_W-1:0] month,
    output logic [DOM_W-1:0]   day_of_month,
    output logic [WDAY_W-1:0]  weekday,
    output logic [DAYS_W-1:0]  day_echo
);

    localparam int unsigned WDAY_FIRST = 1;

    // Stage 1: shift to the March-based era origin
    logic [22:0] s1_z_next, s1_z_reg;

    // Stage 2: era = z / 146097
    logic [46:0] s2_prod;
    logic [5:0]  s2_era_next, s2_era_reg;
    logic [22:0] s2_z_reg;

    // Stage 3: day of era
    logic [22:0] s3_doe_full;
    logic [17:0] s3_doe_reg;
    logic [5:0]  s3_era_reg;

    // Stage 4: leap corrections
    logic [36:0] s4_p1, s4_p2;
    logic [7:0]  s4_q1_next, s4_q1_reg;
    logic [2:0]  s4_q2_next, s4_q2_reg;
    logic        s4_q3_next, s4_q3_reg;
    logic [17:0] s4_doe_reg;
    logic [5:0]  s4_era_reg;

    // Stage 5: corrected day count
    logic [17:0] s5_n_next, s5_n_reg;
    logic [17:0] s5_doe_reg;
    logic [5:0]  s5_era_reg;

    // Stage 6: year of era
    logic [36:0] s6_prod;
    logic [8:0]  s6_yoe_next, s6_yoe_reg;
    logic [17:0] s6_doe_reg;
    logic [5:0]  s6_era_reg;

    // Stage 7: days before the year within the era
    logic [18:0] s7_p100;
    logic [2:0]  s7_q100_next, s7_q100_reg;
    logic [17:0] s7_h_next, s7_h_reg;
    logic [8:0]  s7_yoe_reg;
    logic [17:0] s7_doe_reg;
    logic [5:0]  s7_era_reg;

    // Stage 8: day of year, March-based year
    logic [17:0] s8_doy_full;
    logic [8:0]  s8_doy_reg;
    logic [13:0] s8_y_next, s8_y_reg;

    // Stage 9: March-based month
    logic [10:0] s9_x;
    logic [22:0] s9_prod;
    logic [3:0]  s9_mp_next, s9_mp_reg;
    logic [8:0]  s9_doy_reg;
    logic [13:0] s9_y_reg;

    // Stage 10: civil date
    logic [8:0]         s10_d;
    logic [3:0]         s10_m;
    logic [YEAR_W-1:0]  s10_year_next, year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [DOM_W-1:0]   dom_reg;

    logic [WDAY_W-1:0] s2_wd_next;
    logic [WDAY_W-1:0] wd_reg [WDAY_FIRST:CDDN_STAGES-1];
    logic [DAYS_W-1:0] dn_echo_reg [CDDN_STAGES];

    assign s1_z_next = 23'(day_number) + 23'(EPOCH_OFFSET);

    assign s2_prod     = 47'(s1_z_reg) * 47'(ERA_MUL);
    assign s2_era_next = s2_prod[46:41];
    assign s2_wd_next  = mod7(23'(dn_echo_reg[0]) + 23'(WDAY_EPOCH));

    assign s3_doe_full = s2_z_reg - 23'(s2_era_reg) * 23'(ERA_DAYS);

    assign s4_p1      = 37'(s3_doe_reg) * 37'(DIV1460_MUL);
    assign s4_p2      = 37'(s3_doe_reg) * 37'(DIV36524_MUL);
    assign s4_q1_next = s4_p1[36:29];
    assign s4_q2_next = s4_p2[36:34];
    assign s4_q3_next = (s3_doe_reg == ERA_LAST);

    assign s5_n_next = s4_doe_reg - 18'(s4_q1_reg) + 18'(s4_q2_reg) - 18'(s4_q3_reg);

    assign s6_prod     = 37'(s5_n_reg) * 37'(DIV365_MUL);
    assign s6_yoe_next = s6_prod[35:27];

    assign s7_p100      = 19'(s6_yoe_reg) * 19'(DIV100_MUL);
    assign s7_q100_next = s7_p100[18:16];
    assign s7_h_next    = 18'(s6_yoe_reg) * 18'(YEAR_DAYS) + 18'(s6_yoe_reg[8:2]);

    assign s8_doy_full = s7_doe_reg - s7_h_reg + 18'(s7_q100_reg);
    assign s8_y_next   = 14'(s7_yoe_reg) + 14'(s7_era_reg) * 14'(ERA_YEARS);

    assign s9_x       = 11'(s8_doy_reg) * 11'd5 + 11'd2;
    assign s9_prod    = 23'(s9_x) * 23'(DIV153_MUL);
    assign s9_mp_next = s9_prod[22:19];

    // Back to January-based month; January and February belong to the next year
    always_comb
    begin
        s10_d         = s9_doy_reg - month_start(s9_mp_reg) + 9'd1;
        s10_m         = (s9_mp_reg < 4'd10) ? (s9_mp_reg + 4'd3) : (s9_mp_reg - 4'd9);
        s10_year_next = s9_y_reg + YEAR_W'(s10_m <= MONTH_FEB);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            s1_z_reg <= s1_z_next;
        end
        if (ctrl.load[1])
        begin
            s2_era_reg <= s2_era_next;
            s2_z_reg   <= s1_z_reg;
        end
        if (ctrl.load[2])
        begin
            s3_doe_reg <= s3_doe_full[17:0];
            s3_era_reg <= s2_era_reg;
        end
        if (ctrl.load[3])
        begin
            s4_q1_reg  <= s4_q1_next;
            s4_q2_reg  <= s4_q2_next;
            s4_q3_reg  <= s4_q3_next;
            s4_doe_reg <= s3_doe_reg;
            s4_era_reg <= s3_era_reg;
        end
        if (ctrl.load[4])
        begin
            s5_n_reg   <= s5_n_next;
            s5_doe_reg <= s4_doe_reg;
            s5_era_reg <= s4_era_reg;
        end
        if (ctrl.load[5])
        begin
            s6_yoe_reg <= s6_yoe_next;
            s6_doe_reg <= s5_doe_reg;
            s6_era_reg <= s5_era_reg;
        end
        if (ctrl.load[6])
        begin
            s7_q100_reg <= s7_q100_next;
            s7_h_reg    <= s7_h_next;
            s7_yoe_reg  <= s6_yoe_reg;
            s7_doe_reg  <= s6_doe_reg;
            s7_era_reg  <= s6_era_reg;
        end
        if (ctrl.load[7])
        begin
            s8_doy_reg <= s8_doy_full[8:0];
            s8_y_reg   <= s8_y_next;
        end
        if (ctrl.load[8])
        begin
            s9_mp_reg  <= s9_mp_next;
            s9_doy_reg <= s8_doy_reg;
            s9_y_reg   <= s8_y_reg;
        end
        if (ctrl.load[9])
        begin
            year_reg  <= s10_year_next;
            month_reg <= s10_m;
            dom_reg   <= s10_d[DOM_W-1:0];
        end
        if (ctrl.load[WDAY_FIRST])
        begin
            wd_reg[WDAY_FIRST] <= s2_wd_next;
        end
        if (ctrl.load[0])
        begin
            dn_echo_reg[0] <= day_number;
        end
    end

    // Weekday and input echo ride along
    for (genvar k = WDAY_FIRST + 1; k < CDDN_STAGES; k++)
    begin : g_wd_dly
        always_ff @(posedge clk)
        begin
            if (ctrl.load[k])
            begin
                wd_reg[k] <= wd_reg[k-1];
            end
        end
    end

    for (genvar k = 1; k < CDDN_STAGES; k++)
    begin : g_echo
        always_ff @(posedge clk)
        begin
            if (ctrl.load[k])
            begin
                dn_echo_reg[k] <= dn_echo_reg[k-1];
            end
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = dom_reg;
    assign weekday      = wd_reg[CDDN_STAGES-1];
    assign day_echo     = dn_echo_reg[CDDN_STAGES-1];

endmodule

[src/civil_date_day_number_convert_top.sv]
// Throughput: one word per cycle while the result side takes words; both directions run
// in parallel ten-stage pipelines. A stall on the result side holds every full stage that
// has no empty stage after it; empty stages still fill, so requests keep flowing until
// the pipeline is full.
// Reset (rst_n, asynchronous, active low) empties the pipeline; no clearing pass is needed.
module civil_date_day_number_convert_top
    import cddn_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    cddn_in_if.sink    request,
    cddn_out_if.source result
);

    logic [CDDN_STAGES-1:0] valid_reg;
    logic [CDDN_STAGES-1:0] valid_next;
    logic [CDDN_STAGES-1:0] stage_ready;
    cddn_cmd_t              cmd_reg [CDDN_STAGES];
    cddn_ctrl_t             ctrl;

    logic [DAYS_W-1:0]  date_days;
    logic [WDAY_W-1:0]  date_wd;
    logic [YEAR_W-1:0]  date_year_echo;
    logic [MONTH_W-1:0] date_month_echo;
    logic [DOM_W-1:0]   date_dom_echo;

    logic [YEAR_W-1:0]  day_year;
    logic [MONTH_W-1:0] day_month;
    logic [DOM_W-1:0]   day_dom;
    logic [WDAY_W-1:0]  day_wd;
    logic [DAYS_W-1:0]  day_days_echo;

    // A stage takes a new word when it is empty or the one after it moves on
    assign stage_ready[CDDN_STAGES-1] = !valid_reg[CDDN_STAGES-1] || result.ready;

    for (genvar k = 0; k < CDDN_STAGES - 1; k++)
    begin : g_ready
        assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
    end

    assign ctrl.load     = stage_ready;
    assign request.ready = stage_ready[0];

    // Valid bits and command travel with the data
    assign valid_next[0] = stage_ready[0] ? request.valid : valid_reg[0];

    for (genvar k = 1; k < CDDN_STAGES; k++)
    begin : g_valid
        assign valid_next[k] = stage_ready[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            cmd_reg[0] <= request.data.command;
        end
    end

    for (genvar k = 1; k < CDDN_STAGES; k++)
    begin : g_cmd
        always_ff @(posedge clk)
        begin
            if (stage_ready[k])
            begin
                cmd_reg[k] <= cmd_reg[k-1];
            end
        end
    end

    cddn_date_pipe u_date_pipe (
        .clk          (clk),
        .ctrl         (ctrl),
        .year         (request.data.year),
        .month        (request.data.month),
        .day_of_month (request.data.day_of_month),
        .day_number   (date_days),
        .weekday      (date_wd),
        .year_echo    (date_year_echo),
        .month_echo   (date_month_echo),
        .dom_echo     (date_dom_echo)
    );

    cddn_day_pipe u_day_pipe (
        .clk          (clk),
        .ctrl         (ctrl),
        .day_number   (request.data.day_number),
        .year         (day_year),
        .month        (day_month),
        .day_of_month (day_dom),
        .weekday      (day_wd),
        .day_echo     (day_days_echo)
    );

    // Result word: pick the path the command asked for
    assign result.valid = valid_reg[CDDN_STAGES-1];

    always_comb
    begin
        if (cmd_reg[CDDN_STAGES-1] == CMD_TO_DAYS)
        begin
            result.data.out_day_number   = date_days;
            result.data.out_year         = date_year_echo;
            result.data.out_month        = date_month_echo;
            result.data.out_day_of_month = date_dom_echo;
            result.data.weekday          = date_wd;
        end
        else
        begin
            result.data.out_day_number   = day_days_echo;
            result.data.out_year         = day_year;
            result.data.out_month        = day_month;
            result.data.out_day_of_month = day_dom;
            result.data.weekday          = day_wd;
        end
    end

endmodule
